[rtl/simt_pkg.sv]
// Shared types and constants for the three-list intersect-minus-exclusion block.
package simt_pkg;

  localparam int DEPTH_DEF   = 32;
  localparam int MAX_RESULTS = 32;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 6;
  localparam int REQ_W       = 3;

  localparam logic [REQ_W-1:0] REQ_LOAD_FIRST  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_SECOND = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD_EXCL   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_COMPUTE     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] elem_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic [CNT_W-1:0]        out_count;
    logic                    is_last;
    logic                    is_empty;
    logic                    overflow;
  } out_word_t;

  typedef struct packed {
    logic             v;
    logic             last_tok;
    logic             hit_sec;
    logic             hit_exc;
    logic [VAL_W-1:0] val;
  } tok_t;

  typedef struct packed {
    logic             wr_sec;
    logic             wr_exc;
    logic [VAL_W-1:0] value;
  } load_t;

endpackage

[rtl/simt_cell.sv]
// One compare cell: holds one second-list and one excluded-list entry, passes a probe on.
module simt_cell #(
  parameter int LW  = 6,
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  simt_pkg::load_t ld,
  input  logic [LW-1:0]   sec_len,
  input  logic [LW-1:0]   exc_len,
  input  simt_pkg::tok_t  tok_i,
  output simt_pkg::tok_t  tok_o
);
  import simt_pkg::*;

  logic [VAL_W-1:0] sec_r;
  logic [VAL_W-1:0] exc_r;
  logic             v_r;
  logic             last_r;
  logic             hs_r;
  logic             hx_r;
  logic [VAL_W-1:0] val_r;
  logic             sec_ok;
  logic             exc_ok;

  assign sec_ok = sec_len > LW'(IDX);
  assign exc_ok = exc_len > LW'(IDX);

  always_ff @(posedge clk) begin
    if (ld.wr_sec && sec_len == LW'(IDX)) begin
      sec_r <= ld.value;
    end
    if (ld.wr_exc && exc_len == LW'(IDX)) begin
      exc_r <= ld.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= tok_i.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r <= tok_i.last_tok;
      val_r  <= tok_i.val;
      hs_r   <= tok_i.hit_sec | (sec_ok && tok_i.val == sec_r);
      hx_r   <= tok_i.hit_exc | (exc_ok && tok_i.val == exc_r);
    end
  end

  always_comb begin
    tok_o          = '0;
    tok_o.v        = v_r;
    tok_o.last_tok = last_r;
    tok_o.hit_sec  = hs_r;
    tok_o.hit_exc  = hx_r;
    tok_o.val      = val_r;
  end

endmodule

[rtl/simt_chain.sv]
// Row of compare cells that a first-list probe walks one cell per cycle while en is high.
module simt_chain #(
  parameter int DEPTH = simt_pkg::DEPTH_DEF,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  simt_pkg::load_t ld,
  input  logic [LW-1:0]   sec_len,
  input  logic [LW-1:0]   exc_len,
  input  simt_pkg::tok_t  tok_i,
  output simt_pkg::tok_t  tok_o
);
  import simt_pkg::*;

  tok_t toks [DEPTH+1];

  assign toks[0] = tok_i;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    simt_cell #(
      .LW  (LW),
      .IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ld      (ld),
      .sec_len (sec_len),
      .exc_len (exc_len),
      .tok_i   (toks[k]),
      .tok_o   (toks[k+1])
    );
  end

  assign tok_o = toks[DEPTH];

endmodule

[rtl/set_intersect_minus_third.sv]
// Top level: list loading, first-list sequencer, cell chain and result stage.
// Load and clear words produce no result. A compute word occupies the block until its run
// ends: the first list is read one entry per cycle while the output is not stalled, and
// every probe crosses the DEPTH-cell compare chain. The first result word is registered
// once the next qualifier or the run end reaches the result stage, since each qualifier
// waits for the next one or the run end; output stalls freeze the chain. Reset clears
// list lengths and the overflow flag; no clearing pass.
module set_intersect_minus_third #(
  parameter int DEPTH = simt_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  simt_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output simt_pkg::out_word_t out_data
);
  import simt_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [LW-1:0]    first_len_r, first_len_nxt;
  logic [LW-1:0]    sec_len_r, sec_len_nxt;
  logic [LW-1:0]    exc_len_r, exc_len_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LW-1:0]    idx_r, idx_nxt;
  logic [VAL_W-1:0] first_mem [DEPTH];
  logic             s0_v_r;
  logic             s0_last_r;
  logic [VAL_W-1:0] s0_val_r;
  tok_t             s0_tok;
  tok_t             tail;
  load_t            ld;
  logic             accept;
  logic             en;
  logic             wr_first;
  logic             issue_more;
  logic             qual;
  logic             hold_v_r, hold_v_nxt;
  logic [VAL_W-1:0] hold_val_r, hold_val_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  out_word_t        push_word;
  logic             out_valid_r;
  out_word_t        out_r;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign en         = !out_valid_r || out_ready;
  assign issue_more = idx_r < first_len_r;

  assign wr_first = accept && in_data.req_type == REQ_LOAD_FIRST &&
                    first_len_r < LW'(DEPTH);

  always_comb begin
    ld        = '0;
    ld.wr_sec = accept && in_data.req_type == REQ_LOAD_SECOND && sec_len_r < LW'(DEPTH);
    ld.wr_exc = accept && in_data.req_type == REQ_LOAD_EXCL && exc_len_r < LW'(DEPTH);
    ld.value  = in_data.elem_value;
  end

  always_comb begin
    state_nxt     = state_r;
    first_len_nxt = first_len_r;
    sec_len_nxt   = sec_len_r;
    exc_len_nxt   = exc_len_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.req_type)
            REQ_LOAD_FIRST: begin
              if (first_len_r < LW'(DEPTH)) first_len_nxt = first_len_r + 1'b1;
              else ovf_nxt = 1'b1;
            end
            REQ_LOAD_SECOND: begin
              if (sec_len_r < LW'(DEPTH)) sec_len_nxt = sec_len_r + 1'b1;
              else ovf_nxt = 1'b1;
            end
            REQ_LOAD_EXCL: begin
              if (exc_len_r < LW'(DEPTH)) exc_len_nxt = exc_len_r + 1'b1;
              else ovf_nxt = 1'b1;
            end
            REQ_COMPUTE: begin
              state_nxt = ST_ISSUE;
              idx_nxt   = '0;
            end
            REQ_CLEAR: begin
              first_len_nxt = '0;
              sec_len_nxt   = '0;
              exc_len_nxt   = '0;
              ovf_nxt       = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ISSUE: begin
        if (en) begin
          if (issue_more) idx_nxt = idx_r + 1'b1;
          else state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (en && tail.v && tail.last_tok) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_len_r <= '0;
      sec_len_r   <= '0;
      exc_len_r   <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      first_len_r <= first_len_nxt;
      sec_len_r   <= sec_len_nxt;
      exc_len_r   <= exc_len_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[first_len_r[AW-1:0]] <= in_data.elem_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= (state_r == ST_ISSUE);
    end
  end

  always_ff @(posedge clk) begin
    if (en && state_r == ST_ISSUE) begin
      s0_last_r <= !issue_more;
      s0_val_r  <= first_mem[idx_r[AW-1:0]];
    end
  end

  always_comb begin
    s0_tok          = '0;
    s0_tok.v        = s0_v_r;
    s0_tok.last_tok = s0_last_r;
    s0_tok.val      = s0_val_r;
  end

  simt_chain #(
    .DEPTH (DEPTH),
    .LW    (LW)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ld      (ld),
    .sec_len (sec_len_r),
    .exc_len (exc_len_r),
    .tok_i   (s0_tok),
    .tok_o   (tail)
  );

  assign qual = tail.v && !tail.last_tok && tail.hit_sec && !tail.hit_exc;

  // hold one qualifier back until the next one or the end of the run decides is_last
  always_comb begin
    hold_v_nxt   = hold_v_r;
    hold_val_nxt = hold_val_r;
    cnt_nxt      = cnt_r;
    push         = 1'b0;
    push_word    = '0;
    push_word.overflow = ovf_r;
    priority if (accept && in_data.req_type == REQ_COMPUTE) begin
      cnt_nxt    = '0;
      hold_v_nxt = 1'b0;
    end else if (en && qual && cnt_r != CNT_W'(MAX_RESULTS)) begin
      if (hold_v_r) begin
        push                = 1'b1;
        push_word.out_value = hold_val_r;
        push_word.out_count = cnt_r;
      end
      hold_v_nxt   = 1'b1;
      hold_val_nxt = tail.val;
      cnt_nxt      = cnt_r + 1'b1;
    end else if (en && tail.v && tail.last_tok) begin
      push              = 1'b1;
      push_word.is_last = 1'b1;
      if (hold_v_r) begin
        push_word.out_value = hold_val_r;
        push_word.out_count = cnt_r;
      end else begin
        push_word.is_empty = 1'b1;
      end
      hold_v_nxt = 1'b0;
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      cnt_r    <= cnt_nxt;
      if (push) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    hold_val_r <= hold_val_nxt;
    if (push) out_r <= push_word;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_hold_counted: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> cnt_r != '0)
    else $error("held result without a count");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("result count above cap");

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.is_empty |-> out_r.is_last && out_r.out_count == '0)
    else $error("empty word not marked last with zero count");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    first_len_r <= LW'(DEPTH) && sec_len_r <= LW'(DEPTH) && exc_len_r <= LW'(DEPTH))
    else $error("list length above depth");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !s0_v_r && !hold_v_r)
    else $error("probe or held result left while idle");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for set_intersect_minus_third: queued stimulus, clocked driver and monitor, list predictor.
module tb_top;
  import simt_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int RAND_WORDS   = 280;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 40;
  localparam int HOLD_CYCLES  = 300;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic signed [VAL_W-1:0] lists [3][LIST_DEPTH];
  int                      list_len [3] = '{0, 0, 0};
  logic                    ovf_seen = 1'b0;
  logic [REQ_W-1:0]        load_req [3] = '{REQ_LOAD_FIRST, REQ_LOAD_SECOND, REQ_LOAD_EXCL};
  logic signed [VAL_W-1:0] value_pool [6];

  out_word_t expected_q [$];
  in_word_t  pending_q [$];
  int        words_queued  = 0;
  int        compute_words = 0;
  int        mismatches    = 0;
  int        cycles        = 0;
  bit        word_taken    = 1'b0;
  int        burst_left    = 0;
  int        idle_left     = 0;
  rx_mode_t  rx_mode       = RX_OPEN;
  int        rx_phase_left = 0;
  bit        rx_go         = 1'b0;
  logic      rx_hold       = 1'b0;
  int        hold_left     = 0;
  int        hold_at       = 6;

  set_intersect_minus_third dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit list_holds(input int idx, input logic signed [VAL_W-1:0] v);
    for (int k = 0; k < list_len[idx]; k++) begin
      if (lists[idx][k] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_word(input in_word_t w);
    out_word_t r;
    int        hits;
    hits = 0;
    case (w.req_type)
      REQ_LOAD_FIRST, REQ_LOAD_SECOND, REQ_LOAD_EXCL: begin
        if (list_len[w.req_type] < LIST_DEPTH) begin
          lists[w.req_type][list_len[w.req_type]] = w.elem_value;
          list_len[w.req_type]++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      REQ_CLEAR: begin
        foreach (list_len[k]) list_len[k] = 0;
        ovf_seen = 1'b0;
      end
      REQ_COMPUTE: begin
        compute_words++;
        for (int i = 0; i < list_len[REQ_LOAD_FIRST]; i++) begin
          if (hits < MAX_RESULTS && list_holds(REQ_LOAD_SECOND, lists[REQ_LOAD_FIRST][i]) &&
              !list_holds(REQ_LOAD_EXCL, lists[REQ_LOAD_FIRST][i])) begin
            hits++;
            r.out_value = lists[REQ_LOAD_FIRST][i];
            r.out_count = CNT_W'(hits);
            r.is_last   = 1'b0;
            r.is_empty  = 1'b0;
            r.overflow  = ovf_seen;
            expected_q.push_back(r);
          end
        end
        if (hits == 0) begin
          r          = '0;
          r.is_last  = 1'b1;
          r.is_empty = 1'b1;
          r.overflow = ovf_seen;
          expected_q.push_back(r);
        end else begin
          r = expected_q.pop_back();
          r.is_last = 1'b1;
          expected_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endtask

  function automatic void queue_word(input logic [REQ_W-1:0] req,
                                     input logic signed [VAL_W-1:0] v);
    in_word_t w;
    w.req_type   = req;
    w.elem_value = v;
    pending_q.push_back(w);
    if (req <= REQ_CLEAR) words_queued++;
  endfunction

  function automatic logic signed [VAL_W-1:0] fresh_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pool_value();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return value_pool[$urandom_range(0, 5)];
  endfunction

  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("set_intersect_minus_third regression: fail");
        $finish;
      end else begin
        if (in_valid && in_ready) begin
          predict_word(in_data);
          word_taken = 1'b1;
        end
        if (out_valid && out_ready) begin
          if (expected_q.size() == 0) begin
            note_mismatch($sformatf("unexpected word: value %0d count %0d last %b empty %b ovf %b",
                                    out_data.out_value, out_data.out_count, out_data.is_last,
                                    out_data.is_empty, out_data.overflow));
          end else begin
            want = expected_q.pop_front();
            if (out_data.out_value !== want.out_value || out_data.out_count !== want.out_count ||
                out_data.is_last !== want.is_last || out_data.is_empty !== want.is_empty ||
                out_data.overflow !== want.overflow) begin
              note_mismatch($sformatf({"mismatch: expected value %0d count %0d last %b empty %b",
                                       " ovf %b, got value %0d count %0d last %b empty %b ovf %b"},
                                      want.out_value, want.out_count, want.is_last,
                                      want.is_empty, want.overflow, out_data.out_value,
                                      out_data.out_count, out_data.is_last, out_data.is_empty,
                                      out_data.overflow));
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || word_taken)) begin
      word_taken = 1'b0;
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_data  <= pending_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_t'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(8, 64);
    end else begin
      rx_phase_left--;
    end
    case (rx_mode)
      RX_OPEN:   rx_go = 1'b1;
      RX_COIN:   rx_go = $urandom_range(0, 1);
      RX_SPARSE: rx_go = ($urandom_range(0, 3) == 0);
      default:   rx_go = rx_phase_left[0];
    endcase
    out_ready <= rst_n && !rx_hold && rx_go;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (hold_at > 0 && compute_words >= hold_at) begin
      hold_left = HOLD_CYCLES;
      hold_at   = (hold_at < 20) ? 20 : 0;
    end
    rx_hold <= (hold_left > 0);
  end

  initial begin
    int kind;
    int l;
    int n;
    int fill [3];

    queue_word(REQ_COMPUTE, 32'sd0);
    queue_word(REQ_LOAD_FIRST, 32'sh7FFF_FFFF);
    queue_word(REQ_LOAD_FIRST, 32'sh8000_0000);
    queue_word(REQ_LOAD_FIRST, 32'sd0);
    queue_word(REQ_LOAD_FIRST, -32'sd1);
    queue_word(REQ_LOAD_FIRST, 32'sd5);
    queue_word(REQ_LOAD_FIRST, 32'sd5);
    queue_word(REQ_LOAD_FIRST, 32'sd7);
    queue_word(REQ_LOAD_SECOND, 32'sh8000_0000);
    queue_word(REQ_LOAD_SECOND, -32'sd1);
    queue_word(REQ_LOAD_SECOND, 32'sd5);
    queue_word(REQ_LOAD_SECOND, 32'sd7);
    queue_word(REQ_LOAD_SECOND, 32'sh7FFF_FFFF);
    queue_word(REQ_LOAD_EXCL, 32'sd7);
    queue_word(3'd5, 32'sd5);
    queue_word(3'd6, 32'sh8000_0000);
    queue_word(3'd7, -32'sd1);
    queue_word(REQ_COMPUTE, -32'sd1);
    queue_word(REQ_CLEAR, 32'sh7FFF_FFFF);
    queue_word(REQ_COMPUTE, 32'sd0);

    while (words_queued < RAND_WORDS) begin
      kind = $urandom_range(0, 19);
      foreach (value_pool[k]) value_pool[k] = fresh_value();
      if (kind <= 13) begin
        queue_word(REQ_CLEAR, $urandom);
        foreach (fill[k]) begin
          fill[k] = ($urandom_range(0, 14) == 0) ? $urandom_range(LIST_DEPTH - 1, LIST_DEPTH + 2)
                                                 : $urandom_range(0, 6);
        end
        while (fill[0] + fill[1] + fill[2] > 0) begin
          l = $urandom_range(0, 2);
          if (fill[l] > 0) begin
            queue_word(load_req[l], pool_value());
            fill[l]--;
          end
        end
        queue_word(REQ_COMPUTE, $urandom);
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 4);
          repeat (n) queue_word(load_req[$urandom_range(0, 2)], pool_value());
          queue_word(REQ_COMPUTE, $urandom);
        end
      end else if (kind == 14) begin
        queue_word(REQ_CLEAR, $urandom);
        foreach (value_pool[k]) queue_word(REQ_LOAD_SECOND, value_pool[k]);
        repeat (LIST_DEPTH + 1) queue_word(REQ_LOAD_FIRST, value_pool[$urandom_range(0, 5)]);
        queue_word(REQ_COMPUTE, $urandom);
      end else if (kind <= 16) begin
        n = $urandom_range(1, 6);
        repeat (n) queue_word(REQ_W'($urandom_range(0, 7)), $urandom);
      end else if (kind == 17) begin
        n = $urandom_range(1, 4);
        repeat (n) queue_word(load_req[$urandom_range(0, 2)], pool_value());
        queue_word(REQ_COMPUTE, $urandom);
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) queue_word(load_req[$urandom_range(0, 2)], pool_value());
        queue_word(REQ_CLEAR, $urandom);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("set_intersect_minus_third regression: pass");
    end else begin
      $display("set_intersect_minus_third regression: fail");
    end
    $finish;
  end

endmodule
